// ===== hw/rtl/motr_pkg.sv =====
// shared types, constants and helpers for the motor over-current trip monitor
// no dependencies; imported by every module of the block
package motr_pkg;

    localparam int MOTOR_COUNT = 6;
    localparam int MOTOR_W     = 3;
    localparam int ADC_W       = 10;
    localparam int CUR_W       = 16;
    localparam int LIMIT_W     = 14;
    localparam int CNT_W       = 8;
    localparam int MASK_W      = 6;
    localparam int MAG50_W     = 16;
    localparam int DIV_W       = 24;
    localparam int STEP_W      = 5;
    localparam int ZERO_REGS   = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 14;

    localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(DIV_W - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX       = '1;

    // operation codes on the op field
    localparam logic [2:0] OP_SAMPLE    = 3'd0;
    localparam logic [2:0] OP_ALL_ON    = 3'd1;
    localparam logic [2:0] OP_ALL_OFF   = 3'd2;
    localparam logic [2:0] OP_MOTOR_ON  = 3'd3;
    localparam logic [2:0] OP_MOTOR_OFF = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TRIP  = 3'd7;

    localparam logic [ADC_W-1:0]   ZERO_RESET  = 10'd512;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd5120;
    localparam logic [CNT_W-1:0]   TRIP_RESET  = 8'd3;

    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_SAMPLE,
        KIND_ALL_ON,
        KIND_ALL_OFF,
        KIND_ON,
        KIND_OFF
    } kind_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_FIN
    } back_state_t;

    typedef logic [ZERO_REGS-1:0][ADC_W-1:0] zero_levels_t;

    // one classified item waiting for the back end
    typedef struct packed {
        kind_t               kind;
        logic [MOTOR_W-1:0]  motor;
        logic                neg;
        logic [MAG50_W-1:0]  mag50;
        logic [ADC_W-1:0]    divisor;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [MASK_W-1:0] all_on_mask();
        logic [MASK_W-1:0] m;
        m = '0;
        for (int i = 0; i < MOTOR_COUNT; i++)
        begin
            m[i] = 1'b1;
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/motr_front.sv =====
// front end: takes input beats, classifies the operation and prepares the divide operands
// depends on motr_pkg
module motr_front (
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    op,
    input  logic [motr_pkg::MOTOR_W-1:0]  motor,
    input  logic [motr_pkg::ADC_W-1:0]    adc_sample,
    input  motr_pkg::zero_levels_t        zero_levels,
    input  motr_pkg::q_status_t           q_stat,
    output logic                          push,
    output motr_pkg::job_t                job
);
    import motr_pkg::*;

    logic             motor_ok;
    logic [ADC_W-1:0] zero_sel;
    logic [ADC_W-1:0] divisor;
    logic             neg;
    logic [ADC_W-1:0] mag;

    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;
    assign motor_ok = motor < MOTOR_W'(MOTOR_COUNT);

    always_comb
    begin
        zero_sel = motor_ok ? zero_levels[motor] : ZERO_RESET;
        divisor  = (zero_sel == '0) ? ADC_W'(1) : zero_sel;
        neg      = adc_sample < divisor;
        mag      = neg ? (divisor - adc_sample) : (adc_sample - divisor);

        job.motor   = motor;
        job.neg     = neg;
        job.divisor = divisor;
        // mag * 50 as shifted adds
        job.mag50   = {1'b0, mag, 5'b0} + {2'b0, mag, 4'b0} + {5'b0, mag, 1'b0};

        priority if (op == OP_SAMPLE && motor_ok)
            job.kind = KIND_SAMPLE;
        else if (op == OP_ALL_ON)
            job.kind = KIND_ALL_ON;
        else if (op == OP_ALL_OFF)
            job.kind = KIND_ALL_OFF;
        else if (op == OP_MOTOR_ON && motor_ok)
            job.kind = KIND_ON;
        else if (op == OP_MOTOR_OFF && motor_ok)
            job.kind = KIND_OFF;
        else
            job.kind = KIND_NOP;
    end

endmodule

// ===== hw/rtl/motr_queue.sv =====
// two-entry queue of classified items between front and back end
// depends on motr_pkg
module motr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  motr_pkg::job_t      push_job,
    input  logic                pop,
    output motr_pkg::job_t      head_job,
    output motr_pkg::q_status_t q_stat
);
    import motr_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job     = entry_reg[rd_ptr_reg];
    assign q_stat.full  = count_reg == 2'd2;
    assign q_stat.empty = count_reg == 2'd0;

endmodule

// ===== hw/rtl/motr_back.sv =====
// back end: serial divider, trip counters, enable mask and output register
// depends on motr_pkg
module motr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  motr_pkg::q_status_t           q_stat,
    input  motr_pkg::job_t                head_job,
    output logic                          pop,
    input  logic [motr_pkg::LIMIT_W-1:0]  current_limit,
    input  logic [motr_pkg::CNT_W-1:0]    trip_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [motr_pkg::MOTOR_W-1:0]  motor_out,
    output logic signed [motr_pkg::CUR_W-1:0] current,
    output logic                          over_limit,
    output logic                          tripped,
    output logic [motr_pkg::MASK_W-1:0]   enables
);
    import motr_pkg::*;

    back_state_t                         state_reg, state_next;
    logic [STEP_W-1:0]                   step_reg, step_next;
    logic [ADC_W-1:0]                    rem_reg, rem_next;
    logic [DIV_W-1:0]                    quo_reg, quo_next;
    job_t                                job_reg, job_next;
    logic [MOTOR_COUNT-1:0][CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MASK_W-1:0]                   en_reg, en_next;
    logic                                out_valid_reg, out_valid_next;
    logic [MOTOR_W-1:0]                  motor_out_reg, motor_out_next;
    logic [CUR_W-1:0]                    cur_reg, cur_next;
    logic                                over_reg, over_next;
    logic                                trip_reg, trip_next;

    logic [ADC_W:0]     shifted;
    logic [ADC_W:0]     diff;
    logic [CUR_W-1:0]   cur_sat;
    logic               is_over;
    logic [CNT_W-1:0]   cnt_old;
    logic [CNT_W-1:0]   cnt_new;
    logic               hits_trip;
    logic               slot_free;

    always_comb
    begin
        // one restoring divide step
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        diff    = shifted - {1'b0, job_reg.divisor};

        // saturate the quotient into signed q7.8
        if (job_reg.neg)
            cur_sat = (quo_reg > DIV_W'(32768)) ? 16'h8000 : (~quo_reg[CUR_W-1:0] + 16'd1);
        else
            cur_sat = (quo_reg > DIV_W'(32767)) ? 16'h7FFF : quo_reg[CUR_W-1:0];

        is_over   = $signed({cur_sat[CUR_W-1], cur_sat}) > $signed({3'b000, current_limit});
        cnt_old   = cnt_reg[job_reg.motor];
        cnt_new   = (cnt_old == CNT_MAX) ? CNT_MAX : cnt_old + 8'd1;
        hits_trip = (cnt_new != cnt_old) && (cnt_new == trip_count);
        slot_free = !out_valid_reg || !out_stall;

        state_next     = state_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        job_next       = job_reg;
        cnt_next       = cnt_reg;
        en_next        = en_reg;
        out_valid_next = out_valid_reg && out_stall;
        motor_out_next = motor_out_reg;
        cur_next       = cur_reg;
        over_next      = over_reg;
        trip_next      = trip_reg;
        pop            = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop      = 1'b1;
                    job_next = head_job;
                    rem_next = '0;
                    quo_next = {head_job.mag50, 8'b0};
                    step_next = DIV_LAST_STEP;
                    state_next = (head_job.kind == KIND_SAMPLE) ? B_DIV : B_FIN;
                end
            end
            B_DIV:
            begin
                if (!diff[ADC_W])
                begin
                    rem_next = diff[ADC_W-1:0];
                    quo_next = {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[ADC_W-1:0];
                    quo_next = {quo_reg[DIV_W-2:0], 1'b0};
                end
                step_next = step_reg - 5'd1;
                if (step_reg == '0)
                begin
                    state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                if (slot_free)
                begin
                    cur_next  = '0;
                    over_next = 1'b0;
                    trip_next = 1'b0;
                    unique case (job_reg.kind)
                        KIND_SAMPLE:
                        begin
                            cur_next = cur_sat;
                            if (is_over)
                            begin
                                over_next = 1'b1;
                                cnt_next[job_reg.motor] = cnt_new;
                                if (hits_trip)
                                begin
                                    trip_next = 1'b1;
                                    en_next[job_reg.motor] = 1'b0;
                                end
                            end
                            else
                            begin
                                cnt_next[job_reg.motor] = '0;
                            end
                        end
                        KIND_ALL_ON:  en_next = all_on_mask();
                        KIND_ALL_OFF: en_next = '0;
                        KIND_ON:      en_next[job_reg.motor] = 1'b1;
                        KIND_OFF:     en_next[job_reg.motor] = 1'b0;
                        default:      ;
                    endcase
                    motor_out_next = job_reg.motor;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            en_reg        <= all_on_mask();
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            en_reg        <= en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg      <= step_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        job_reg       <= job_next;
        motor_out_reg <= motor_out_next;
        cur_reg       <= cur_next;
        over_reg      <= over_next;
        trip_reg      <= trip_next;
    end

    assign out_valid  = out_valid_reg;
    assign motor_out  = motor_out_reg;
    assign current    = $signed(cur_reg);
    assign over_limit = over_reg;
    assign tripped    = trip_reg;
    assign enables    = en_reg;

endmodule

// ===== hw/rtl/motor_overcurrent_trip_monitor.sv =====
// per-motor over-current trip monitor, top level
// samples pass one at a time through the 24-step serial divider; other ops skip the divider
// the two-entry queue takes input beats until full while the divider runs or the output stalls
// reset (rst_n, async, active low): zero levels 512, limit 5120, trip count 3,
// counters cleared, all motors enabled, queue and output empty
module motor_overcurrent_trip_monitor (
    input  logic                             clk,
    input  logic                             rst_n,
    // input beats
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [2:0]                       op,
    input  logic [motr_pkg::MOTOR_W-1:0]     motor,
    input  logic [motr_pkg::ADC_W-1:0]       adc_sample,
    // result beats
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [motr_pkg::MOTOR_W-1:0]     motor_out,
    output logic signed [motr_pkg::CUR_W-1:0] current,
    output logic                             over_limit,
    output logic                             tripped,
    output logic [motr_pkg::MASK_W-1:0]      enables,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [motr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [motr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import motr_pkg::*;

    zero_levels_t       zero_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]   trip_reg;

    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      head_job;
    q_status_t q_stat;

    // configuration is always taken at once
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ZERO_REGS; i++)
            begin
                zero_reg[i] <= ZERO_RESET;
            end
            limit_reg <= LIMIT_RESET;
            trip_reg  <= TRIP_RESET;
        end
        else if (cfg_valid)
        begin
            priority if (cfg_index == REG_LIMIT)
                limit_reg <= cfg_data;
            else if (cfg_index == REG_TRIP)
                trip_reg <= cfg_data[CNT_W-1:0];
            else
                zero_reg[cfg_index] <= cfg_data[ADC_W-1:0];
        end
    end

    // front end: classify the op, pick the zero level, form the divide operands
    motr_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .motor       (motor),
        .adc_sample  (adc_sample),
        .zero_levels (zero_reg),
        .q_stat      (q_stat),
        .push        (push),
        .job         (push_job)
    );

    // decouples acceptance from the slow back end
    motr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    // back end: divider, trip logic and the output register
    motr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .head_job      (head_job),
        .pop           (pop),
        .current_limit (limit_reg),
        .trip_count    (trip_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .motor_out     (motor_out),
        .current       (current),
        .over_limit    (over_limit),
        .tripped       (tripped),
        .enables       (enables)
    );

endmodule
